[hdl/lge_pkg.sv]
// Shared types, constants and the B3/S23 cell rule for the life grid engine.
`default_nettype none

package lge_pkg;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_READ   = 2'd3
  } lge_cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } lge_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_STEP,
    ST_DONE
  } lge_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic cnt_inc;
    logic sweep_clear;
    logic rd_cell;
    logic wr_toggle;
    logic step_run;
    logic out_load;
  } lge_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    lge_cmd_t cmd;
    logic     in_area;
    logic     sweep_last;
    logic     step_last;
    logic     out_free;
  } lge_sts_t;

  function automatic logic life_next(input logic alive, input logic [3:0] count);
    logic res;
    res = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_LOW));
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/lge_ctrl.sv]
// Controller state machine that sequences clear, toggle, read and step commands.
`default_nettype none

module lge_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lge_pkg::lge_cmd_t in_cmd,
  input  lge_pkg::lge_sts_t sts,
  output lge_pkg::lge_ctl_t ctl
);
  import lge_pkg::*;

  lge_state_t state_r;
  lge_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        ctl.sweep_clear = 1'b1;
        ctl.cnt_inc     = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load    = 1'b1;
          ctl.cnt_clr = 1'b1;
          case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_STEP:  state_nxt = ST_STEP;
            default:   state_nxt = ST_RD_ISSUE;
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.sweep_clear = 1'b1;
        ctl.cnt_inc     = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_ISSUE: begin
        // A cell outside the area answers without touching the grid.
        if (sts.in_area) begin
          ctl.rd_cell = 1'b1;
          state_nxt   = ST_RD_DATA;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_DATA: begin
        ctl.wr_toggle = (sts.cmd == CMD_TOGGLE);
        state_nxt     = ST_DONE;
      end
      ST_STEP: begin
        ctl.step_run = 1'b1;
        ctl.cnt_inc  = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/lge_datapath.sv]
// Datapath: size registers, grid memory, three-row step window and result register.
`default_nettype none

module lge_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]   cfg_data,
  input  logic [lge_pkg::CMD_W-1:0]   in_command,
  input  logic [lge_pkg::COORD_W-1:0] in_row,
  input  logic [lge_pkg::COORD_W-1:0] in_col,
  input  lge_pkg::lge_ctl_t           ctl,
  output lge_pkg::lge_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_cell_alive,
  output logic                        out_in_range
);
  import lge_pkg::*;

  localparam int RA_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int HB_W  = $clog2(MAX_HEIGHT + 2);
  localparam int SZ_W  = (HB_W > CFG_W) ? HB_W : CFG_W;

  logic [CFG_W-1:0]     width_r;
  logic [CFG_W-1:0]     height_r;
  logic [CFG_W-1:0]     eff_w;
  logic [SZ_W-1:0]      h_ext;
  logic [SZ_W-1:0]      eff_h;
  logic [MAX_WIDTH-1:0] col_mask;

  lge_cmd_t             cmd_r;
  logic [COORD_W-1:0]   row_r;
  logic [COORD_W-1:0]   col_r;
  logic                 inside_r;
  logic [SZ_W-1:0]      cnt_r;
  logic [SZ_W-1:0]      cnt_nxt;

  logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data_r;
  logic [MAX_WIDTH-1:0] above_r;
  logic [MAX_WIDTH-1:0] center_r;
  logic [MAX_WIDTH-1:0] below;
  logic [MAX_WIDTH-1:0] life_row;
  logic                 below_ok;

  logic                 mem_we;
  logic [RA_W-1:0]      mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [RA_W-1:0]      mem_raddr;

  logic                 cell_bit;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_cell_alive_r;
  logic                 out_in_range_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (lge_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= width_r;
      endcase
    end
  end

  // Zero means one, and anything above the grid saturates.
  always_comb begin
    h_ext = SZ_W'(height_r);
    if (width_r == '0) begin
      eff_w = CFG_W'(1);
    end else if (width_r > CFG_W'(MAX_WIDTH)) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (h_ext == '0) begin
      eff_h = SZ_W'(1);
    end else if (h_ext > SZ_W'(MAX_HEIGHT)) begin
      eff_h = SZ_W'(MAX_HEIGHT);
    end else begin
      eff_h = h_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = (CFG_W'(i) < eff_w);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= lge_cmd_t'(in_command);
      row_r    <= in_row;
      col_r    <= in_col;
      inside_r <= (SZ_W'(in_row) < eff_h) && (CFG_W'(in_col) < eff_w);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (ctl.cnt_inc) begin
      cnt_nxt = SZ_W'(cnt_r + SZ_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // During a step, the count is the row being read; the row two above it is
  // written back, so every row is read before its new value lands.
  assign below_ok = (cnt_r != '0) && (cnt_r <= eff_h);
  assign below    = below_ok ? (rd_data_r & col_mask) : '0;

  always_comb begin
    logic [MAX_WIDTH+1:0] a_p;
    logic [MAX_WIDTH+1:0] c_p;
    logic [MAX_WIDTH+1:0] b_p;
    logic [3:0]           count;
    a_p = {1'b0, above_r & col_mask, 1'b0};
    c_p = {1'b0, center_r & col_mask, 1'b0};
    b_p = {1'b0, below, 1'b0};
    for (int i = 0; i < MAX_WIDTH; i++) begin
      count = 4'(a_p[i]) + 4'(a_p[i+1]) + 4'(a_p[i+2]) + 4'(c_p[i]) + 4'(c_p[i+2])
            + 4'(b_p[i]) + 4'(b_p[i+1]) + 4'(b_p[i+2]);
      life_row[i] = life_next(c_p[i+1], count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_clr) begin
      above_r  <= '0;
      center_r <= '0;
    end else if (ctl.step_run) begin
      above_r  <= center_r;
      center_r <= below_ok ? rd_data_r : '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = RA_W'(cnt_r);
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = RA_W'(cnt_r);
    if (ctl.sweep_clear) begin
      mem_we = 1'b1;
    end else if (ctl.wr_toggle) begin
      mem_we    = 1'b1;
      mem_waddr = RA_W'(row_r);
      mem_wdata = rd_data_r ^ (MAX_WIDTH'(1) << COL_W'(col_r));
    end else if (ctl.step_run) begin
      mem_we    = (cnt_r >= SZ_W'(2));
      mem_waddr = RA_W'(cnt_r - SZ_W'(2));
      // Columns outside the area keep their old values.
      mem_wdata = (life_row & col_mask) | (center_r & ~col_mask);
      mem_re    = (cnt_r < eff_h);
    end
    if (ctl.rd_cell) begin
      mem_re    = 1'b1;
      mem_raddr = RA_W'(row_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_raddr];
    end
  end

  assign cell_bit = rd_data_r[COL_W'(col_r)];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_in_range_r <= inside_r && ((cmd_r == CMD_TOGGLE) || (cmd_r == CMD_READ));
      case (cmd_r)
        CMD_TOGGLE: out_cell_alive_r <= inside_r && !cell_bit;
        CMD_READ:   out_cell_alive_r <= inside_r && cell_bit;
        default:    out_cell_alive_r <= 1'b0;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_alive_r;
  assign out_in_range   = out_in_range_r;

  always_comb begin
    sts.cmd        = cmd_r;
    sts.in_area    = inside_r;
    sts.sweep_last = (cnt_r == SZ_W'(MAX_HEIGHT - 1));
    sts.step_last  = (cnt_r == SZ_W'(eff_h + SZ_W'(1)));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

[hdl/life_automaton_grid_engine_unit.sv]
// Top level of the life grid engine: controller and datapath joined.
//
//  Channel   Direction  Handshake             Word
//  cfg_*     in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  in_*      in         in_valid/in_ready     in_command, in_row, in_col
//  out_*     out        out_valid/out_ready   out_cell_alive, out_in_range
//
// One command word is taken at a time. Read and toggle read the addressed row
// (not for a cell outside the area); clear and step use one grid memory port
// sweeping a row per cycle, over all rows for clear and the rows in use for step.
// The next command is taken in the cycle after the result is loaded.
// After reset a clearing pass over every grid row runs with in_ready low.
// A result waiting in the output register that is not taken blocks the next command.
`default_nettype none

module life_automaton_grid_engine_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lge_pkg::CMD_W-1:0]   in_command,
  input  logic [lge_pkg::COORD_W-1:0] in_row,
  input  logic [lge_pkg::COORD_W-1:0] in_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_cell_alive,
  output logic                        out_in_range
);
  import lge_pkg::*;

  lge_ctl_t ctl;
  lge_sts_t sts;

  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (lge_cmd_t'(in_command)),
    .sts      (sts),
    .ctl      (ctl)
  );

  lge_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_row         (in_row),
    .in_col         (in_col),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive),
    .out_in_range   (out_in_range)
  );

endmodule

`default_nettype wire

[hdl/lge_checker.sv]
// Port-level checks for the life grid engine and their binding to the top level.
`default_nettype none

module lge_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_cell_alive,
  input logic       out_in_range
);

  // After reset the grid is being cleared, so nothing is taken or shown.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("command taken or result shown right after reset");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in work");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_alive)
      && $stable(out_in_range))
    else $error("stalled result word changed or dropped");

  // A result word always carries a live cell only when it lies in range.
  a_alive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_alive |-> out_in_range)
    else $error("live cell reported outside the area");

endmodule

bind life_automaton_grid_engine_unit lge_checker u_lge_checker (.*);

`default_nettype wire

[verif/life_automaton_grid_engine_unit_tb.sv]
// Self-checking testbench for the life grid engine: commands, cell answers and B3/S23 steps.
`timescale 1ns / 100ps

module life_automaton_grid_engine_unit_tb;
  import lge_pkg::*;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic alive;
    logic ranged;
  } cell_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = CMD_CLEAR;
  logic [COORD_W-1:0] in_row = '0;
  logic [COORD_W-1:0] in_col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_cell_alive;
  logic out_in_range;

  // Model of the grid and the size registers.
  logic [GRID_COLS-1:0] grid_model [GRID_ROWS];
  logic [CFG_W-1:0] width_reg = SIZE_RESET;
  logic [CFG_W-1:0] height_reg = SIZE_RESET;

  cell_answer_t answer_q[$];
  cell_answer_t want_ans;
  int error_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  life_automaton_grid_engine_unit #(
    .MAX_WIDTH (GRID_COLS),
    .MAX_HEIGHT(GRID_ROWS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_alive(out_cell_alive),
    .out_in_range  (out_in_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < GRID_ROWS; i++) grid_model[i] = '0;
  end

  // ---------------------------------------------------------------- model

  function automatic int area_cols();
    if (width_reg == 0) return 1;
    if (width_reg > GRID_COLS) return GRID_COLS;
    return int'(width_reg);
  endfunction

  function automatic int area_rows();
    if (height_reg == 0) return 1;
    if (height_reg > GRID_ROWS) return GRID_ROWS;
    return int'(height_reg);
  endfunction

  // Next generation of the area in use; everything outside it counts as dead and is left untouched.
  function automatic void evolve_grid();
    logic [GRID_COLS-1:0] snap [GRID_ROWS];
    int h;
    int w;
    int neighbors;
    int rr;
    int cc;
    h = area_rows();
    w = area_cols();
    snap = grid_model;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        neighbors = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
              neighbors += snap[rr][cc];
          end
        end
        grid_model[r][c] = (neighbors == int'(BIRTH_COUNT)) ||
                           (snap[r][c] && neighbors == int'(SURVIVE_LOW));
      end
    end
  endfunction

  function automatic cell_answer_t predict_answer(lge_cmd_t cmd, logic [COORD_W-1:0] row,
                                                  logic [COORD_W-1:0] col);
    cell_answer_t ans;
    logic in_area;
    ans = '0;
    in_area = (int'(row) < area_rows()) && (int'(col) < area_cols());
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < GRID_ROWS; i++) grid_model[i] = '0;
      end
      CMD_TOGGLE: begin
        if (in_area) begin
          grid_model[row][col] = ~grid_model[row][col];
          ans.alive = grid_model[row][col];
          ans.ranged = 1'b1;
        end
      end
      CMD_STEP: evolve_grid();
      default: begin
        if (in_area) begin
          ans.alive = grid_model[row][col];
          ans.ranged = 1'b1;
        end
      end
    endcase
    return ans;
  endfunction

  // ------------------------------------------------------------- drivers

  // Sends one command word; valid stays high on return so back-to-back words need no gap.
  task automatic send_cmd(lge_cmd_t cmd, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_row <= row;
    in_col <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answer_q.push_back(predict_answer(cmd, row, col));
  endtask

  // Lowers valid and waits until every answer is back and the block has settled.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_area(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= cols;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = cols;
    cfg_index <= REG_HEIGHT;
    cfg_data <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = rows;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // ------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        if (error_count < 10)
          $display("unexpected word: alive=%0b in_range=%0b", out_cell_alive, out_in_range);
        error_count++;
      end else begin
        want_ans = answer_q.pop_front();
        if (out_cell_alive !== want_ans.alive || out_in_range !== want_ans.ranged) begin
          if (error_count < 10)
            $display("mismatch: alive exp %0b got %0b, in_range exp %0b got %0b",
                     want_ans.alive, out_cell_alive, want_ans.ranged, out_in_range);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[life_automaton_grid_engine_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------- tests

  // Default 64 x 64 area straight out of reset: everything reads dead.
  task automatic test_reset_state();
    send_cmd(CMD_READ, 0, 0);
    send_cmd(CMD_READ, 63, 63);
    send_cmd(CMD_STEP, 0, 0);
  endtask

  task automatic test_cell_access();
    send_cmd(CMD_TOGGLE, 0, 0);
    send_cmd(CMD_TOGGLE, 63, 63);
    send_cmd(CMD_READ, 63, 63);
    send_cmd(CMD_TOGGLE, 0, 0);
    send_cmd(CMD_CLEAR, 17, 42);
    send_cmd(CMD_READ, 63, 63);
  endtask

  // A blinker in the open and one against the right edge; the edge one must not
  // wrap over to column 0.
  task automatic test_evolution_edges();
    send_cmd(CMD_TOGGLE, 10, 9);
    send_cmd(CMD_TOGGLE, 10, 10);
    send_cmd(CMD_TOGGLE, 10, 11);
    send_cmd(CMD_TOGGLE, 5, 63);
    send_cmd(CMD_TOGGLE, 6, 63);
    send_cmd(CMD_TOGGLE, 7, 63);
    send_cmd(CMD_STEP, 0, 0);
    send_cmd(CMD_READ, 9, 10);
    send_cmd(CMD_READ, 10, 9);
    send_cmd(CMD_READ, 6, 62);
    send_cmd(CMD_READ, 6, 0);
  endtask

  // Small area, zero sizes, oversized registers; hidden cells come back when it grows.
  task automatic test_area_limits();
    drain_answers();
    set_area(3, 2);
    send_cmd(CMD_TOGGLE, 1, 2);
    send_cmd(CMD_TOGGLE, 2, 0);
    send_cmd(CMD_READ, 0, 3);
    drain_answers();
    set_area(0, 0);
    send_cmd(CMD_READ, 0, 0);
    send_cmd(CMD_READ, 0, 1);
    drain_answers();
    set_area(127, 127);
    send_cmd(CMD_READ, 1, 2);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows, int count);
    int pick;
    lge_cmd_t cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    drain_answers();
    set_area(cols, rows);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) cmd = CMD_CLEAR;
      else if (pick < 45) cmd = CMD_TOGGLE;
      else if (pick < 58) cmd = CMD_STEP;
      else cmd = CMD_READ;
      // Mostly cells inside the area, so the pattern gets dense enough to evolve.
      if ($urandom_range(99) < 85) begin
        row = COORD_W'($urandom_range(area_rows() - 1));
        col = COORD_W'($urandom_range(area_cols() - 1));
      end else begin
        row = COORD_W'($urandom_range(GRID_ROWS - 1));
        col = COORD_W'($urandom_range(GRID_COLS - 1));
      end
      send_cmd(cmd, row, col);
    end
  endtask

  task automatic test_random_phases();
    run_phase(8, 8, 300);
    run_phase(1, 1, 60);
    run_phase(64, 64, 150);
    run_phase(5, 12, 200);
    run_phase(127, 0, 60);
    run_phase(0, 127, 80);
    run_phase(3, 3, 100);
    no_idle = 1'b1;
    run_phase(16, 10, 250);
    no_idle = 1'b0;
    for (int i = 0; i < 4; i++)
      run_phase(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)), 90);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_cell_access();
    test_evolution_edges();
    test_area_limits();
    test_random_phases();
    drain_answers();
    repeat (GRID_ROWS + 8) @(posedge clk);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("[life_automaton_grid_engine_unit] OK");
    end else begin
      $display("[life_automaton_grid_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lge_pkg.sv
hdl/lge_ctrl.sv
hdl/lge_datapath.sv
hdl/life_automaton_grid_engine_unit.sv
hdl/lge_checker.sv
verif/life_automaton_grid_engine_unit_tb.sv
